// ----- hdl/tspb_pkg.sv -----
// Shared types and constants for the TCP SYN probe builder.
// No dependencies.
`default_nettype none

package tspb_pkg;

  localparam int unsigned PacketLen = 40;
  localparam int unsigned IdxW      = 6;

  // Fixed 16-bit words of the TCP checksum: protocol, TCP length,
  // offset/flags word and window. All other fixed TCP words are zero.
  localparam logic [15:0] ProtoTcp   = 16'd6;
  localparam logic [15:0] TcpHdrLen  = 16'd20;
  localparam logic [15:0] OffsetSyn  = 16'h5002;
  localparam logic [15:0] WindowSize = 16'd1024;
  localparam logic [17:0] CsumConst  = 18'(ProtoTcp) + 18'(TcpHdrLen)
                                     + 18'(OffsetSyn) + 18'(WindowSize);

  localparam logic [7:0] VerIhl   = 8'h45;
  localparam logic [7:0] TotLenLo = 8'd40;
  localparam logic [7:0] TtlValue = 8'd64;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PacketLen - 1);

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [15:0] src_port;
  } probe_t;

endpackage

`default_nettype wire

// ----- hdl/tspb_csum.sv -----
// Four-stage pipeline that computes the TCP checksum of a probe.
// Depends on tspb_pkg.
`default_nettype none

module tspb_csum import tspb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire probe_t      probe_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output probe_t           probe_o,
  output logic [15:0]      csum_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  probe_t p1_q, p2_q, p3_q, p4_q;
  logic [17:0] part_a_q, part_b_q;
  logic [18:0] sum_q;
  logic [15:0] csum_q;
  logic [16:0] fold1, fold2;

  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign fold1 = 17'(sum_q[18:16]) + 17'(sum_q[15:0]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q <= probe_i;
    end
    if (en2) begin
      p2_q     <= p1_q;
      part_a_q <= 18'(p1_q.src_addr[31:16]) + 18'(p1_q.src_addr[15:0])
                + 18'(p1_q.dst_addr[31:16]);
      part_b_q <= 18'(p1_q.dst_addr[15:0]) + 18'(p1_q.src_port)
                + 18'(p1_q.dst_port) + CsumConst;
    end
    if (en3) begin
      p3_q  <= p2_q;
      sum_q <= 19'(part_a_q) + 19'(part_b_q);
    end
    if (en4) begin
      p4_q   <= p3_q;
      csum_q <= ~fold2[15:0];
    end
  end

  assign valid_o = v4_q;
  assign probe_o = p4_q;
  assign csum_o  = csum_q;

endmodule

`default_nettype wire

// ----- hdl/tcp_syn_probe_builder_core.sv -----
// A request passes the four checksum stages and the serializer register before its
// first byte is valid. The one-byte output serializer sends 40 beats per packet;
// up to four further requests queue in the checksum pipeline meanwhile.
// Reset: asynchronous active low; clears all valid bits, byte index and source address.
// Top level of the TCP SYN probe builder; depends on tspb_pkg and tspb_csum.
`default_nettype none

module tcp_syn_probe_builder_core import tspb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] dest_address_i,
  input  wire logic [15:0] dest_port_i,
  input  wire logic [15:0] source_port_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       packet_byte_o,
  output logic             last_byte_o
);

  logic [31:0]     src_addr_q;
  probe_t          req;
  probe_t          cs_probe;
  logic [15:0]     cs_csum;
  logic            cs_valid;
  logic            ser_load;
  logic            ser_v_q;
  probe_t          ser_p_q;
  logic [15:0]     ser_csum_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            is_last;
  logic            beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= '0;
    end else if (cfg_we_i) begin
      src_addr_q <= cfg_wdata_i;
    end
  end

  assign req.src_addr = src_addr_q;
  assign req.dst_addr = dest_address_i;
  assign req.dst_port = dest_port_i;
  assign req.src_port = source_port_i;

  tspb_csum u_csum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .probe_i (req),
    .valid_o (cs_valid),
    .ready_i (ser_load),
    .probe_o (cs_probe),
    .csum_o  (cs_csum)
  );

  // Serializer
  assign is_last  = (idx_q == LastIdx);
  assign beat     = ser_v_q && out_ready_i;
  assign ser_load = !ser_v_q || (beat && is_last);

  always_comb begin
    idx_d = idx_q;
    if (beat) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (ser_load) ser_v_q <= cs_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load && cs_valid) begin
      ser_p_q    <= cs_probe;
      ser_csum_q <= cs_csum;
    end
  end

  always_comb begin
    case (idx_q)
      6'd0:    packet_byte_o = VerIhl;
      6'd3:    packet_byte_o = TotLenLo;
      6'd8:    packet_byte_o = TtlValue;
      6'd9:    packet_byte_o = ProtoTcp[7:0];
      6'd12:   packet_byte_o = ser_p_q.src_addr[31:24];
      6'd13:   packet_byte_o = ser_p_q.src_addr[23:16];
      6'd14:   packet_byte_o = ser_p_q.src_addr[15:8];
      6'd15:   packet_byte_o = ser_p_q.src_addr[7:0];
      6'd16:   packet_byte_o = ser_p_q.dst_addr[31:24];
      6'd17:   packet_byte_o = ser_p_q.dst_addr[23:16];
      6'd18:   packet_byte_o = ser_p_q.dst_addr[15:8];
      6'd19:   packet_byte_o = ser_p_q.dst_addr[7:0];
      6'd20:   packet_byte_o = ser_p_q.src_port[15:8];
      6'd21:   packet_byte_o = ser_p_q.src_port[7:0];
      6'd22:   packet_byte_o = ser_p_q.dst_port[15:8];
      6'd23:   packet_byte_o = ser_p_q.dst_port[7:0];
      6'd32:   packet_byte_o = OffsetSyn[15:8];
      6'd33:   packet_byte_o = OffsetSyn[7:0];
      6'd34:   packet_byte_o = WindowSize[15:8];
      6'd35:   packet_byte_o = WindowSize[7:0];
      6'd36:   packet_byte_o = ser_csum_q[15:8];
      6'd37:   packet_byte_o = ser_csum_q[7:0];
      default: packet_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o = ser_v_q;
  assign last_byte_o = is_last;

endmodule

`default_nettype wire

// ----- bench/tcp_syn_probe_builder_core_test.sv -----
// Testbench for tcp_syn_probe_builder_core: sends probe requests, rebuilds each SYN packet
// and its TCP checksum locally, and compares every output byte in wire order.
// Depends only on the tcp_syn_probe_builder_core RTL (and tspb_csum and tspb_pkg below it).
`timescale 1ns / 100ps

module tcp_syn_probe_builder_core_test;

  localparam int unsigned SynLen      = 40;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned SettleTicks = 8;
  localparam logic [7:0]  SynVerIhl   = 8'h45;
  localparam logic [7:0]  SynTtl      = 8'd64;
  localparam logic [7:0]  SynProto    = 8'd6;
  localparam logic [15:0] SynTcpLen   = 16'd20;
  localparam logic [15:0] SynOffFlags = 16'h5002;
  localparam logic [15:0] SynWindow   = 16'd1024;

  typedef struct {
    logic [7:0] octet;
    logic       is_last;
  } wire_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] dest_address_i;
  logic [15:0] dest_port_i;
  logic [15:0] source_port_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  packet_byte_o;
  logic        last_byte_o;

  wire_byte_t      pending_bytes_q[$];
  wire_byte_t      head_byte;
  logic [31:0]     local_ip;
  int unsigned     send_max;
  int unsigned     recv_max;
  int unsigned     probes_sent;
  int unsigned     bytes_checked;
  int unsigned     ip_settings;
  int unsigned     mismatch_count;
  int unsigned     cycle_count;

  tcp_syn_probe_builder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .dest_address_i (dest_address_i),
    .dest_port_i    (dest_port_i),
    .source_port_i  (source_port_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_byte_o  (packet_byte_o),
    .last_byte_o    (last_byte_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Ones-complement fold of everything but the source port, so the
  // returned port makes the folded sum 0xffff and the checksum zero.
  function automatic logic [15:0] zero_sum_sport(input logic [31:0] src,
                                                 input logic [31:0] dst,
                                                 input logic [15:0] dport);
    logic [31:0] acc;
    acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + SynProto + SynTcpLen
        + dport + SynOffFlags + SynWindow;
    acc = acc[31:16] + acc[15:0];
    acc = acc + acc[31:16];
    return ~acc[15:0];
  endfunction

  task automatic predict_syn_packet(input logic [31:0] src, input logic [31:0] dst,
                                    input logic [15:0] dport, input logic [15:0] sport);
    logic [7:0]  pkt [SynLen];
    logic [31:0] acc;
    logic [15:0] csum;
    wire_byte_t  wb;
    for (int i = 0; i < SynLen; i++) pkt[i] = 8'h00;
    pkt[0] = SynVerIhl;
    pkt[3] = 8'(SynLen);
    pkt[8] = SynTtl;
    pkt[9] = SynProto;
    {pkt[12], pkt[13], pkt[14], pkt[15]} = src;
    {pkt[16], pkt[17], pkt[18], pkt[19]} = dst;
    {pkt[20], pkt[21]} = sport;
    {pkt[22], pkt[23]} = dport;
    {pkt[32], pkt[33]} = SynOffFlags;
    {pkt[34], pkt[35]} = SynWindow;
    acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + SynProto + SynTcpLen;
    for (int i = 20; i < SynLen; i += 2) acc = acc + {pkt[i], pkt[i + 1]};
    acc = acc[31:16] + acc[15:0];
    acc = acc + acc[31:16];
    csum = ~acc[15:0];
    {pkt[36], pkt[37]} = csum;
    for (int i = 0; i < SynLen; i++) begin
      wb.octet   = pkt[i];
      wb.is_last = (i == SynLen - 1);
      pending_bytes_q.push_back(wb);
    end
  endtask

  task automatic send_probe(input logic [31:0] dst, input logic [15:0] dport,
                            input logic [15:0] sport);
    int unsigned gap;
    gap = (send_max == 0) ? 0 : $urandom_range(0, send_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dest_address_i <= dst;
    dest_port_i    <= dport;
    source_port_i  <= sport;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_syn_packet(local_ip, dst, dport, sport);
    probes_sent++;
  endtask

  task automatic send_random_probe();
    logic [31:0] dst;
    logic [15:0] dport;
    logic [15:0] sport;
    int unsigned pick;
    dst   = $urandom;
    dport = 16'($urandom_range(0, 65535));
    sport = 16'($urandom_range(0, 65535));
    pick  = $urandom_range(0, 15);
    case (pick)
      0: dst = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      1: begin
        dport = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        sport = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      2: sport = zero_sum_sport(local_ip, dst, dport);
      default: ;
    endcase
    send_probe(dst, dport, sport);
  endtask

  // Sender idles until every expected byte is back, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_local_ip(input logic [31:0] ip);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ip;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    local_ip = ip;
    ip_settings++;
  endtask

  task automatic test_reset_source();
    send_max = 3;
    recv_max = 3;
    send_probe(32'h0A00_0001, 16'd80, 16'd40000);
    send_probe(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_field_extremes();
    write_local_ip(32'hFFFF_FFFF);
    send_probe(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_probe(32'h0000_0000, 16'h0000, 16'h0000);
    send_probe(32'hAAAA_AAAA, 16'hAAAA, 16'h5555);
    send_probe(32'h5555_5555, 16'h5555, 16'hAAAA);
    drain();
    write_local_ip(32'h0000_0000);
    send_probe(32'h8000_0001, 16'h8001, 16'h0001);
    send_probe(32'h0000_0000, 16'h0000, 16'h0000);
    send_probe(32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
    drain();
  endtask

  task automatic test_zero_checksum();
    logic [31:0] dst;
    logic [15:0] dport;
    send_probe(32'h0, 16'h0, zero_sum_sport(local_ip, 32'h0, 16'h0));
    drain();
    write_local_ip(32'hC0A8_0001);
    dst   = $urandom;
    dport = 16'($urandom_range(0, 65535));
    send_probe(dst, dport, zero_sum_sport(local_ip, dst, dport));
    drain();
    write_local_ip(32'hFFFF_FFFF);
    send_probe(32'hFFFF_FFFF, 16'hFFFF, zero_sum_sport(local_ip, 32'hFFFF_FFFF, 16'hFFFF));
    drain();
  endtask

  task automatic test_full_rate();
    send_max = 0;
    recv_max = 0;
    write_local_ip(32'h7F00_0001);
    repeat (5) send_random_probe();
    drain();
  endtask

  task automatic test_random_phases();
    logic [31:0] ip_list [5];
    ip_list[0] = $urandom;
    ip_list[1] = 32'h0000_0000;
    ip_list[2] = 32'hFFFF_FFFF;
    ip_list[3] = $urandom;
    ip_list[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      send_max = (p == 1 || p == 3) ? 0 : 14;
      recv_max = (p == 1 || p == 2) ? 0 : 14;
      write_local_ip(ip_list[p]);
      for (int n = 0; n < 40; n++) begin
        if (n == 20 && (p == 0 || p == 4)) drain();
        send_random_probe();
      end
      drain();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 32'h0;
    in_valid_i     <= 1'b0;
    dest_address_i <= 32'h0;
    dest_port_i    <= 16'h0;
    source_port_i  <= 16'h0;
    local_ip       = 32'h0;
    send_max       = 0;
    recv_max       = 0;
    probes_sent    = 0;
    bytes_checked  = 0;
    ip_settings    = 0;
    mismatch_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_source();
    test_field_extremes();
    test_zero_checksum();
    test_full_rate();
    test_random_phases();
    $display("summary: %0d probe requests, %0d packet bytes checked, %0d source addresses",
             probes_sent, bytes_checked, ip_settings);
    $display("summary: field extremes, zero checksum, full-rate bursts, random stalls");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Output side: a fresh stall drawn for every beat.
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = (recv_max == 0) ? 0 : $urandom_range(0, recv_max);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes_q.size() == 0) begin
        $error("unexpected packet beat: packet_byte %02h last_byte %0b",
               packet_byte_o, last_byte_o);
        mismatch_count++;
      end else begin
        head_byte = pending_bytes_q.pop_front();
        if (packet_byte_o !== head_byte.octet) begin
          $error("packet_byte expected %02h actual %02h", head_byte.octet, packet_byte_o);
          mismatch_count++;
        end
        if (last_byte_o !== head_byte.is_last) begin
          $error("last_byte expected %0b actual %0b", head_byte.is_last, last_byte_o);
          mismatch_count++;
        end
        bytes_checked++;
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ----- tcp_syn_probe_builder_core.f -----
hdl/tspb_pkg.sv
hdl/tspb_csum.sv
hdl/tcp_syn_probe_builder_core.sv
bench/tcp_syn_probe_builder_core_test.sv
